[sv/zbse_pkg.sv]
// Shared types for the zero-byte stuffing encoder: FSM states, command and status bundles.
`timescale 1ns / 1ps
`default_nettype none
package zbse_pkg;

	// Controller states, one-hot
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CODE  = 5'b00010,
		ST_RD    = 5'b00100,
		ST_EMIT  = 5'b01000,
		ST_DELIM = 5'b10000
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;      // input beat taken this cycle
		logic load_code;   // load code byte into output register
		logic load_data;   // load buffered byte into output register
		logic load_delim;  // load frame delimiter into output register
		logic rd_issue;    // read run buffer at current index
		logic idx_clear;
		logic idx_inc;
		logic clear_run;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic cnt_full;    // packet already holds the maximum payload
		logic in_zero;     // input byte is zero
		logic slot_free;   // output register can take a new beat
		logic run_zero;    // run buffer is empty
		logic idx_last;    // index points at the last byte of the run
	} status_t;

endpackage
`default_nettype wire

[sv/zero_byte_stuffing_encoder.sv]
// Top level of the zero-byte stuffing encoder: controller and datapath.
//
// COBS-style encoder without the 254-byte group limit. Payload bytes come in one
// beat at a time, last_byte marking the end of the packet. Non-zero bytes are
// stored in a run buffer (a MAX_PAYLOAD-deep memory). A zero byte closes the
// current group: the block sends a code byte (run length plus one) followed by the
// buffered run. The last byte closes the final group the same way, then a zero
// delimiter goes out with frame_end set and overflow set if any payload byte past
// MAX_PAYLOAD was dropped. A non-zero byte that is not last is taken back to
// back. A group flush sends the code byte, then for each buffered byte a memory
// read followed by an output load; the delimiter follows the final group. Input
// is held off while a flush is in progress, and output backpressure stalls the
// flush. The output register lets a new input beat be taken while the previous
// result still waits. The run buffer needs no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module zero_byte_stuffing_encoder #(
	parameter int MAX_PAYLOAD = 62
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire  [7:0] in_byte,
	input  wire        last_byte,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [7:0] out_byte,
	output logic       frame_end,
	output logic       overflow
);

	zbse_pkg::cmd_t    cmd;
	zbse_pkg::status_t status;

	// Sequencing: accept, flush groups, send delimiter
	zbse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_byte (last_byte),
		.in_ready  (in_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Storage, counters and the output register
	zbse_dp #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (in_byte),
		.cmd       (cmd),
		.status    (status),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.frame_end (frame_end),
		.overflow  (overflow)
	);

endmodule
`default_nettype wire

[sv/zbse_dp.sv]
// Datapath of the zero-byte stuffing encoder: run buffer, counters, output register.
`timescale 1ns / 1ps
`default_nettype none
module zbse_dp #(
	parameter int MAX_PAYLOAD = 62
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire  [7:0]          in_byte,
	input  wire  zbse_pkg::cmd_t cmd,
	output zbse_pkg::status_t   status,
	input  wire                 out_ready,
	output logic                out_valid,
	output logic [7:0]          out_byte,
	output logic                frame_end,
	output logic                overflow
);

	localparam int CW = $clog2(MAX_PAYLOAD + 1);
	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	logic [7:0]    run_mem [MAX_PAYLOAD];
	logic [7:0]    rd_q;
	logic [CW-1:0] run_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] idx_q;
	logic          ovf_q;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          frame_end_q;
	logic          overflow_q;
	logic          store;

	assign status.cnt_full  = (count_q >= CW'(MAX_PAYLOAD));
	assign status.in_zero   = (in_byte == 8'd0);
	assign status.slot_free = !out_valid_q || out_ready;
	assign status.run_zero  = (run_q == '0);
	assign status.idx_last  = ((CW'(idx_q) + CW'(1)) == run_q);

	assign store = cmd.accept && !status.cnt_full && !status.in_zero;

	// Run buffer: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (store) begin
			run_mem[run_q[AW-1:0]] <= in_byte;
		end
		if (cmd.rd_issue) begin
			rd_q <= run_mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= '0;
			count_q <= '0;
			idx_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (cmd.accept) begin
				if (status.cnt_full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
			if (store) begin
				run_q <= run_q + CW'(1);
			end else if (cmd.clear_run) begin
				run_q <= '0;
			end
			if (cmd.idx_clear) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + AW'(1);
			end
			if (cmd.load_delim) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_code || cmd.load_data || cmd.load_delim) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_code) begin
			out_byte_q  <= 8'(run_q) + 8'd1;
			frame_end_q <= 1'b0;
			overflow_q  <= 1'b0;
		end else if (cmd.load_data) begin
			out_byte_q  <= rd_q;
			frame_end_q <= 1'b0;
			overflow_q  <= 1'b0;
		end else if (cmd.load_delim) begin
			out_byte_q  <= 8'd0;
			frame_end_q <= 1'b1;
			overflow_q  <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign frame_end = frame_end_q;
	assign overflow  = overflow_q;

endmodule
`default_nettype wire

[sv/zbse_ctrl.sv]
// Controller FSM of the zero-byte stuffing encoder: sequences group flushes and the delimiter.
`timescale 1ns / 1ps
`default_nettype none
module zbse_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	input  wire                   last_byte,
	output logic                  in_ready,
	input  wire  zbse_pkg::status_t status,
	output zbse_pkg::cmd_t        cmd
);

	zbse_pkg::state_t state_q;
	zbse_pkg::state_t state_d;
	zbse_pkg::state_t after_flush;
	logic             last_q;
	logic             last_d;
	logic             zflush_q;
	logic             zflush_d;
	logic             zflush_new;

	assign in_ready   = (state_q == zbse_pkg::ST_IDLE);
	assign zflush_new = !status.cnt_full && status.in_zero;

	// Where to go when a group flush finishes
	always_comb begin
		if (zflush_q && last_q) begin
			after_flush = zbse_pkg::ST_CODE;
		end else if (last_q) begin
			after_flush = zbse_pkg::ST_DELIM;
		end else begin
			after_flush = zbse_pkg::ST_IDLE;
		end
	end

	always_comb begin
		state_d  = state_q;
		last_d   = last_q;
		zflush_d = zflush_q;
		cmd      = '0;
		case (state_q)
			zbse_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					last_d     = last_byte;
					zflush_d   = zflush_new;
					if (zflush_new || last_byte) begin
						state_d = zbse_pkg::ST_CODE;
					end
				end
			end
			zbse_pkg::ST_CODE: begin
				if (status.slot_free) begin
					cmd.load_code = 1'b1;
					cmd.idx_clear = 1'b1;
					if (status.run_zero) begin
						cmd.clear_run = 1'b1;
						zflush_d      = 1'b0;
						state_d       = after_flush;
					end else begin
						state_d = zbse_pkg::ST_RD;
					end
				end
			end
			zbse_pkg::ST_RD: begin
				cmd.rd_issue = 1'b1;
				state_d      = zbse_pkg::ST_EMIT;
			end
			zbse_pkg::ST_EMIT: begin
				if (status.slot_free) begin
					cmd.load_data = 1'b1;
					cmd.idx_inc   = 1'b1;
					if (status.idx_last) begin
						cmd.clear_run = 1'b1;
						zflush_d      = 1'b0;
						state_d       = after_flush;
					end else begin
						state_d = zbse_pkg::ST_RD;
					end
				end
			end
			zbse_pkg::ST_DELIM: begin
				if (status.slot_free) begin
					cmd.load_delim = 1'b1;
					last_d         = 1'b0;
					state_d        = zbse_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = zbse_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= zbse_pkg::ST_IDLE;
			last_q   <= 1'b0;
			zflush_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			last_q   <= last_d;
			zflush_q <= zflush_d;
		end
	end

endmodule
`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for the zero-byte stuffing encoder.
`timescale 1ns / 1ps
module tb;

	// Payload limit of the block; bytes beyond it are dropped and flagged.
	localparam int PAYLOAD_MAX = 62;
	// Length of the forced receiver hold-off, in cycles.
	localparam int HOLD_CYCLES = 300;

	// One frame beat as it leaves the block.
	typedef struct packed {
		logic [7:0] b;
		logic       fe;
		logic       ovf;
	} frame_beat_t;

	// One directed stimulus row. A non-zero n_exp means the frame beats this
	// payload byte releases are typed in below (the last one carries frame_end
	// when the row is marked last); otherwise the stuffing predictor decides.
	typedef struct packed {
		logic [7:0]      b;
		logic            lst;
		logic [1:0]      n_exp;
		logic [0:2][7:0] exp_b;
		logic            exp_ovf;
	} stim_row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       last_byte;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       frame_end;
	logic       overflow;

	zero_byte_stuffing_encoder #(
		.MAX_PAYLOAD(PAYLOAD_MAX)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte (out_byte),
		.frame_end(frame_end),
		.overflow (overflow)
	);

	// Stuffing predictor state: the pending run of non-zero bytes, the bytes
	// taken in the current packet and the sticky drop flag.
	logic [7:0] run_mem [PAYLOAD_MAX];
	int         run_len;
	int         pay_cnt;
	logic       ovf_seen;

	// Frame beats released by the latest payload byte, and the queue of frame
	// beats still owed by the block, oldest first.
	frame_beat_t pred_q[$];
	frame_beat_t frame_q[$];

	// Run statistics.
	int err_cnt;
	int items_sent;
	int pkt_cnt;
	int ovf_pkts;
	int beats_seen;

	// Idle rates in percent, set per phase by the stimulus process.
	int send_idle_pct;
	int recv_idle_pct;

	// Hold-off handshake: the stimulus bumps hold_ask, the receiver notices
	// the change and counts the stretch down on its own.
	int hold_ask;
	int hold_seen;
	int hold_left;

	stim_row_t dir_rows [18];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#3_000_000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic report(input string what);
		err_cnt++;
		if (err_cnt <= 40)
			$display("mismatch at %0t ns: %s", $time, what);
	endtask

	// Close the current group: code byte (run length plus one), then the run.
	function automatic void close_group();
		pred_q.push_back(frame_beat_t'{b: 8'(run_len + 1), fe: 1'b0, ovf: 1'b0});
		for (int k = 0; k < run_len; k++)
			pred_q.push_back(frame_beat_t'{b: run_mem[k], fe: 1'b0, ovf: 1'b0});
		run_len = 0;
	endfunction

	// Advance the predictor by one accepted payload byte and collect the frame
	// beats it releases in pred_q.
	function automatic void encode_beat(input logic [7:0] b, input logic lst);
		pred_q.delete();
		if (pay_cnt >= PAYLOAD_MAX) begin
			// Payload full: drop the byte, remember it for the delimiter.
			ovf_seen = 1'b1;
		end else begin
			pay_cnt++;
			if (b == 8'h00) begin
				close_group();
			end else if (run_len < PAYLOAD_MAX) begin
				run_mem[run_len] = b;
				run_len++;
			end
		end
		if (lst) begin
			// Final group, then the delimiter; a dropped last byte still closes.
			close_group();
			pred_q.push_back(frame_beat_t'{b: 8'h00, fe: 1'b1, ovf: ovf_seen});
			if (ovf_seen)
				ovf_pkts++;
			pkt_cnt++;
			pay_cnt = 0;
			ovf_seen = 1'b0;
		end
	endfunction

	function automatic stim_row_t plain_row(input logic [7:0] b, input logic lst);
		return stim_row_t'{b: b, lst: lst, n_exp: 2'd0, exp_b: '0, exp_ovf: 1'b0};
	endfunction

	function automatic stim_row_t checked_row(input logic [7:0] b, input logic lst,
			input logic [1:0] n, input logic [7:0] e0, input logic [7:0] e1,
			input logic [7:0] e2);
		return stim_row_t'{b: b, lst: lst, n_exp: n, exp_b: {e0, e1, e2}, exp_ovf: 1'b0};
	endfunction

	// Offer one payload beat and hold it until the block takes it. Call at a
	// rising edge; returns at the edge that accepted the beat, with in_valid
	// still high so back-to-back beats need no gap.
	task automatic send_beat(input stim_row_t row);
		int gap;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		in_byte   <= row.b;
		last_byte <= row.lst;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		encode_beat(row.b, row.lst);
		if (row.n_exp != 2'd0) begin
			// Typed-in beats replace the prediction for this row.
			for (int i = 0; i < int'(row.n_exp); i++)
				frame_q.push_back(frame_beat_t'{b: row.exp_b[i],
					fe: row.lst && (i == int'(row.n_exp) - 1), ovf: row.exp_ovf});
		end else begin
			foreach (pred_q[i])
				frame_q.push_back(pred_q[i]);
		end
	endtask

	// Packet of non-zero bytes, optionally closed by a zero; long ones overflow.
	task automatic send_long(input int len, input bit zero_last);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			b = (zero_last && i == len - 1) ? 8'h00 : 8'($urandom_range(1, 255));
			send_beat(plain_row(b, i == len - 1));
		end
	endtask

	// Random short packet with plenty of zeros and all-ones bytes.
	task automatic send_rand_packet();
		int len;
		int pick;
		logic [7:0] b;
		len = $urandom_range(1, 8);
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(7);
			if (pick < 2)
				b = 8'h00;
			else if (pick == 2)
				b = 8'hFF;
			else
				b = 8'($urandom_range(1, 255));
			send_beat(plain_row(b, i == len - 1));
		end
	endtask

	// Drop valid and wait until every owed frame beat has come out.
	task automatic drain();
		in_valid <= 1'b0;
		while (frame_q.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: check each accepted frame beat against the oldest owed one,
	// then pick out_ready for the next cycle.
	always @(posedge clk) begin : frame_mon
		frame_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			beats_seen++;
			if (frame_q.size() == 0) begin
				report($sformatf("unexpected frame beat %02h", out_byte));
			end else begin
				want = frame_q.pop_front();
				if (out_byte !== want.b)
					report($sformatf("out_byte %02h, want %02h", out_byte, want.b));
				if (frame_end !== want.fe)
					report($sformatf("frame_end %b, want %b", frame_end, want.fe));
				if (overflow !== want.ovf)
					report($sformatf("overflow %b, want %b", overflow, want.ovf));
			end
		end
		// A new hold request starts a long stretch with ready low.
		if (hold_seen != hold_ask) begin
			hold_seen = hold_ask;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		int target;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_byte       = 8'h00;
		last_byte     = 1'b0;
		out_ready     = 1'b0;
		err_cnt       = 0;
		items_sent    = 0;
		pkt_cnt       = 0;
		ovf_pkts      = 0;
		beats_seen    = 0;
		hold_ask      = 0;
		hold_seen     = 0;
		hold_left     = 0;
		run_len       = 0;
		pay_cnt       = 0;
		ovf_seen      = 1'b0;
		send_idle_pct = 13;
		recv_idle_pct = 64;

		// Directed rows: lone zero, lone 0xFF, zeros closing groups, zero runs,
		// alternating bit patterns, a zero as last byte and mixed groups.
		dir_rows = '{
			checked_row(8'h00, 1'b1, 2'd3, 8'h01, 8'h01, 8'h00),
			checked_row(8'hFF, 1'b1, 2'd3, 8'h02, 8'hFF, 8'h00),
			plain_row(8'h01, 1'b0),
			plain_row(8'h80, 1'b0),
			plain_row(8'h00, 1'b0),
			checked_row(8'h7F, 1'b1, 2'd3, 8'h02, 8'h7F, 8'h00),
			checked_row(8'h00, 1'b0, 2'd1, 8'h01, 8'h00, 8'h00),
			checked_row(8'h00, 1'b0, 2'd1, 8'h01, 8'h00, 8'h00),
			checked_row(8'h00, 1'b1, 2'd3, 8'h01, 8'h01, 8'h00),
			plain_row(8'h55, 1'b0),
			plain_row(8'hAA, 1'b0),
			plain_row(8'h00, 1'b1),
			checked_row(8'h01, 1'b1, 2'd3, 8'h02, 8'h01, 8'h00),
			plain_row(8'hC3, 1'b0),
			plain_row(8'h00, 1'b0),
			plain_row(8'h3C, 1'b0),
			plain_row(8'h00, 1'b0),
			plain_row(8'hFE, 1'b1)
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase one: sender idles a little, receiver a lot.
		foreach (dir_rows[i])
			send_beat(dir_rows[i]);
		// Payload limit: a full run, then a dropped byte and a dropped zero that
		// still closes the frame.
		send_long(PAYLOAD_MAX + 2, 1'b1);
		target = items_sent + 10;
		while (items_sent < target)
			send_rand_packet();
		// Pause the sender until the block has emptied.
		drain();

		// Phase two: the other way round.
		send_idle_pct = 64;
		recv_idle_pct = 13;
		target = items_sent + 10;
		while (items_sent < target)
			send_rand_packet();
		drain();

		// Phase three: no idling. Hold the receiver off for a long stretch while
		// a long run and more packets keep coming, so the block backs up.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_ask++;
		send_long(12, 1'b1);
		target = items_sent + 6;
		while (items_sent < target)
			send_rand_packet();
		drain();
		// Let any stray beat out before the verdict.
		repeat (20) @(posedge clk);

		$display("run covered %0d packets (%0d with dropped bytes), %0d payload beats",
			pkt_cnt, ovf_pkts, items_sent);
		$display("checked %0d frame beats across three idle mixes and a long hold-off",
			beats_seen);
		if (err_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
